// File: sv/br1bd_pkg.sv
// shared types and constants of the byterun1 bitplane body decoder
// depends on nothing; imported by every module of the block
`default_nettype none

package br1bd_pkg;

    // geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_PLANES = 8;

    // field and counter widths
    localparam int DIM_W   = 12;
    localparam int PLANE_W = 4;
    localparam int TOTAL_W = 23;
    localparam int DATA_W  = 8;
    localparam int INDEX_W = 3;

    // register indexes of the configuration port
    localparam logic [INDEX_W-1:0] CFG_IMAGE_WIDTH        = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_IMAGE_HEIGHT       = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_INTERLEAVED_PLANES = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_PLANE_COUNT        = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_HAS_MASK_PLANE     = 3'd4;
    localparam logic [INDEX_W-1:0] CFG_COMPRESSED         = 3'd5;

    // command byte codes
    localparam logic [DATA_W-1:0] CMD_NOP = 8'd128;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_body;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] repeat_count;
        logic       image_done;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_LIT,
        PH_RUN,
        PH_PAD
    } phase_t;

    // derived image geometry handed from config block to the decoder
    typedef struct packed {
        logic [DIM_W-1:0]   row_bytes;
        logic [PLANE_W-1:0] depth;
        logic               has_mask;
        logic               compressed;
        logic               width_odd;
        logic [TOTAL_W-1:0] total_bytes;
        logic               busy;
    } geom_t;

endpackage

`default_nettype wire

// File: sv/br1bd_cfg.sv
// configuration registers and derived image geometry (two register stages)
// depends on br1bd_pkg
`default_nettype none

module br1bd_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [br1bd_pkg::INDEX_W-1:0]    cfg_index,
    input  wire logic [br1bd_pkg::DIM_W-1:0]      cfg_data,
    output br1bd_pkg::geom_t                      geom
);
    import br1bd_pkg::*;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               interleaved_reg;
    logic [PLANE_W-1:0] plane_count_reg;
    logic               mask_reg;
    logic               compressed_reg;
    logic [1:0]         wait_reg;
    logic [1:0]         wait_next;

    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;
    logic [DIM_W-1:0]   row_bytes_calc;
    logic [PLANE_W-1:0] depth_calc;

    logic [DIM_W-1:0]         row_bytes_reg;
    logic [PLANE_W-1:0]       depth_reg;
    logic                     geo_mask_reg;
    logic                     geo_comp_reg;
    logic                     width_odd_reg;
    logic [DIM_W+PLANE_W-1:0] hd_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic [DIM_W+PLANE_W+DIM_W-1:0] total_full;

    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= 12'd320;
            height_reg      <= 12'd200;
            interleaved_reg <= 1'b0;
            plane_count_reg <= 4'd8;
            mask_reg        <= 1'b0;
            compressed_reg  <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:        width_reg       <= cfg_data;
                CFG_IMAGE_HEIGHT:       height_reg      <= cfg_data;
                CFG_INTERLEAVED_PLANES: interleaved_reg <= cfg_data[0];
                CFG_PLANE_COUNT:        plane_count_reg <= cfg_data[PLANE_W-1:0];
                CFG_HAS_MASK_PLANE:     mask_reg        <= cfg_data[0];
                CFG_COMPRESSED:         compressed_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // settle counter: geometry is held busy after reset or a write until it has passed stage a and stage b
    always_comb begin
        if (cfg_write) begin
            wait_next = 2'd2;
        end else if (wait_reg != 2'd0) begin
            wait_next = wait_reg - 2'd1;
        end else begin
            wait_next = wait_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg <= 2'd2;
        end else begin
            wait_reg <= wait_next;
        end
    end

    // clamped width, height and plane depth
    always_comb begin
        if (width_reg == '0) begin
            width_eff = 12'd1;
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
        height_eff = (height_reg == '0) ? 12'd1 : height_reg;
        if (interleaved_reg) begin
            row_bytes_calc = DIM_W'(({1'b0, width_eff} + 13'd7) >> 3);
        end else begin
            row_bytes_calc = width_eff;
        end
        if (!interleaved_reg || plane_count_reg == '0) begin
            depth_calc = 4'd1;
        end else if (plane_count_reg > PLANE_W'(MAX_PLANES)) begin
            depth_calc = PLANE_W'(MAX_PLANES);
        end else begin
            depth_calc = plane_count_reg;
        end
    end

    // stage a: height times depth
    always_ff @(posedge aclk) begin
        row_bytes_reg <= row_bytes_calc;
        depth_reg     <= depth_calc;
        geo_mask_reg  <= mask_reg;
        geo_comp_reg  <= compressed_reg;
        width_odd_reg <= width_eff[0];
        hd_reg        <= {{PLANE_W{1'b0}}, height_eff} * {{DIM_W{1'b0}}, depth_calc};
    end

    // stage b: total image bytes
    assign total_full = {{DIM_W{1'b0}}, hd_reg} * {{(DIM_W+PLANE_W){1'b0}}, row_bytes_reg};

    always_ff @(posedge aclk) begin
        total_reg <= total_full[TOTAL_W-1:0];
    end

    always_comb begin
        geom.row_bytes   = row_bytes_reg;
        geom.depth       = depth_reg;
        geom.has_mask    = geo_mask_reg;
        geom.compressed  = geo_comp_reg;
        geom.width_odd   = width_odd_reg;
        geom.total_bytes = total_reg;
        geom.busy        = (wait_reg != 2'd0);
    end

    // checks
    a_write_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> (wait_reg == 2'd2))
        else $error("config write did not restart settle count");

    a_settle_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (wait_reg != 2'd0 && !cfg_write) |=> (wait_reg == $past(wait_reg) - 2'd1))
        else $error("settle count did not step down");

endmodule

`default_nettype wire

// File: sv/br1bd_step.sv
// decode state, one-byte step logic and result register
// depends on br1bd_pkg
`default_nettype none

module br1bd_step (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire br1bd_pkg::geom_t     geom,
    input  wire logic                 in_vld,
    input  wire br1bd_pkg::in_item_t  in_item,
    output logic                      in_take,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output br1bd_pkg::out_item_t      m_data
);
    import br1bd_pkg::*;

    phase_t             phase_reg,    phase_next;
    logic [7:0]         lit_left_reg, lit_left_next;
    logic [DIM_W-1:0]   row_pos_reg,  row_pos_next;
    logic [PLANE_W-1:0] plane_reg,    plane_next;
    logic               skip_reg,     skip_next;
    logic [TOTAL_W-1:0] emitted_reg,  emitted_next;
    logic               finished_reg, finished_next;
    logic               out_vld_reg,  out_vld_next;
    out_item_t          out_reg,      out_next;

    // state as seen after an optional start-of-body clear
    phase_t             cur_phase;
    logic [7:0]         cur_lit;
    logic [DIM_W-1:0]   cur_row;
    logic [PLANE_W-1:0] cur_plane;
    logic               cur_skip;
    logic [TOTAL_W-1:0] cur_emitted;
    logic               cur_finished;

    logic               active;
    logic               fire;
    logic [7:0]         b;
    logic [PLANE_W-1:0] plane_inc;
    logic [DIM_W-1:0]   row_inc;
    logic               has_result;
    logic [7:0]         want_count;
    logic [7:0]         count;
    logic [TOTAL_W-1:0] left;

    assign b       = in_item.stream_byte;
    assign fire    = in_vld && !geom.busy && (!out_vld_reg || m_ready);
    assign in_take = fire;

    always_comb begin
        if (in_item.start_of_body) begin
            cur_phase    = PH_CMD;
            cur_lit      = '0;
            cur_row      = '0;
            cur_plane    = '0;
            cur_skip     = 1'b0;
            cur_emitted  = '0;
            cur_finished = 1'b0;
        end else begin
            cur_phase    = phase_reg;
            cur_lit      = lit_left_reg;
            cur_row      = row_pos_reg;
            cur_plane    = plane_reg;
            cur_skip     = skip_reg;
            cur_emitted  = emitted_reg;
            cur_finished = finished_reg;
        end
    end

    assign active    = !(cur_finished || cur_emitted >= geom.total_bytes);
    assign plane_inc = cur_plane + 4'd1;
    assign row_inc   = cur_row + 12'd1;

    // next decode state
    always_comb begin
        phase_next    = cur_phase;
        lit_left_next = cur_lit;
        row_pos_next  = cur_row;
        plane_next    = cur_plane;
        skip_next     = cur_skip;
        if (active && geom.compressed) begin
            case (cur_phase)
                PH_LIT: begin
                    lit_left_next = cur_lit - 8'd1;
                    if (lit_left_next == 8'd0) begin
                        phase_next = PH_CMD;
                    end
                end
                PH_RUN: begin
                    phase_next = PH_CMD;
                end
                default: begin
                    // command byte, with row segment advance first
                    phase_next = PH_CMD;
                    if (cur_row >= geom.row_bytes) begin
                        plane_next = plane_inc;
                        if ((!geom.has_mask && {1'b0, plane_inc} >= {1'b0, geom.depth}) ||
                            (geom.has_mask &&
                             {1'b0, plane_inc} >= ({1'b0, geom.depth} + 5'd1))) begin
                            plane_next = '0;
                            skip_next  = 1'b0;
                        end
                        if (geom.has_mask && plane_next == geom.depth) begin
                            skip_next = 1'b1;
                        end
                        row_pos_next = '0;
                    end
                    if (b < CMD_NOP) begin
                        lit_left_next = b + 8'd1;
                        phase_next    = PH_LIT;
                        row_pos_next  = row_pos_next + {4'b0, lit_left_next};
                    end else if (b > CMD_NOP) begin
                        lit_left_next = 8'd1 - b;
                        phase_next    = PH_RUN;
                        row_pos_next  = row_pos_next + {4'b0, lit_left_next};
                    end
                end
            endcase
        end else if (active) begin
            // raw rows
            phase_next = PH_CMD;
            if (cur_phase == PH_PAD) begin
                row_pos_next = '0;
                plane_next   = '0;
                skip_next    = 1'b0;
            end else if (cur_skip) begin
                row_pos_next = row_inc;
                if (row_inc >= geom.row_bytes) begin
                    row_pos_next = '0;
                    plane_next   = '0;
                    skip_next    = 1'b0;
                    phase_next   = geom.width_odd ? PH_PAD : PH_CMD;
                end
            end else begin
                row_pos_next = row_inc;
                if (row_inc >= geom.row_bytes) begin
                    row_pos_next = '0;
                    plane_next   = plane_inc;
                    if (plane_inc >= geom.depth) begin
                        if (geom.has_mask) begin
                            skip_next = 1'b1;
                        end else begin
                            plane_next = '0;
                            skip_next  = 1'b0;
                            phase_next = geom.width_odd ? PH_PAD : PH_CMD;
                        end
                    end
                end
            end
        end
    end

    // result and byte count
    always_comb begin
        has_result = 1'b0;
        want_count = 8'd0;
        if (active) begin
            if (geom.compressed) begin
                case (cur_phase)
                    PH_LIT: begin
                        has_result = !cur_skip;
                        want_count = 8'd1;
                    end
                    PH_RUN: begin
                        has_result = !cur_skip;
                        want_count = cur_lit;
                    end
                    default: ;
                endcase
            end else if (cur_phase != PH_PAD && !cur_skip) begin
                has_result = 1'b1;
                want_count = 8'd1;
            end
        end
        // clip at the end of the image
        left  = geom.total_bytes - cur_emitted;
        count = ({15'b0, want_count} > left) ? left[7:0] : want_count;
        emitted_next  = cur_emitted;
        finished_next = cur_finished;
        if (!active) begin
            finished_next = 1'b1;
        end else if (has_result) begin
            emitted_next = cur_emitted + {15'b0, count};
            if (emitted_next >= geom.total_bytes) begin
                finished_next = 1'b1;
            end
        end
        out_next.pixel_value  = b;
        out_next.repeat_count = count;
        out_next.image_done   = finished_next;
        if (fire) begin
            out_vld_next = has_result;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CMD;
            lit_left_reg <= '0;
            row_pos_reg  <= '0;
            plane_reg    <= '0;
            skip_reg     <= 1'b0;
            emitted_reg  <= '0;
            finished_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (fire) begin
                phase_reg    <= phase_next;
                lit_left_reg <= lit_left_next;
                row_pos_reg  <= row_pos_next;
                plane_reg    <= plane_next;
                skip_reg     <= skip_next;
                emitted_reg  <= emitted_next;
                finished_reg <= finished_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // checks
    a_done_means_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.image_done) |-> finished_reg)
        else $error("done flagged without finished state");

    a_literal_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LIT) |-> (lit_left_reg != 8'd0))
        else $error("literal phase with no bytes left");

    a_result_registered: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && has_result) |=> (out_vld_reg && out_reg.repeat_count != 8'd0))
        else $error("result lost or empty");

endmodule

`default_nettype wire

// File: sv/byterun1_bitplane_body_decoder_unit.sv
// byterun1 bitplane body decoder: top level with input register
// input and result register; a result is valid in the cycle after the step takes its byte
// one byte per cycle while geometry is not busy and the output is not stalled;
// bytes causing no result leave no bubble; a config write holds processing while the
// image size product goes through its two register stages (the same after reset)
// reset is synchronous, active low, clears all decode state and handshakes
`default_nettype none

module byterun1_bitplane_body_decoder_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire br1bd_pkg::in_item_t             s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output br1bd_pkg::out_item_t                 m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [br1bd_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [br1bd_pkg::DIM_W-1:0]     cfg_data
);
    import br1bd_pkg::*;

    geom_t     geom;
    logic      in_vld_reg;
    logic      in_vld_next;
    in_item_t  in_reg;
    logic      in_take;

    br1bd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // input register, refilled in the cycle it drains
    assign s_ready = !in_vld_reg || in_take;

    always_comb begin
        if (s_ready) begin
            in_vld_next = s_valid;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    br1bd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .in_vld  (in_vld_reg),
        .in_item (in_reg),
        .in_take (in_take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !in_take) |=> (in_vld_reg && $stable(in_reg)))
        else $error("pending transaction dropped from input register");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for byterun1_bitplane_body_decoder_unit: body bytes, geometry writes, pixel checks
// decoded runs are predicted by a behavioral decoder kept in this file
// depends on br1bd_pkg and the decoder top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import br1bd_pkg::*;

    // number of body bytes to send
    localparam int ITEM_TARGET = 1850;

    // dut ports
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_item_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_item_t          m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]   cfg_data  = '0;

    // geometry as last written to the block
    logic [DIM_W-1:0]   geo_width       = 12'd320;
    logic [DIM_W-1:0]   geo_height      = 12'd200;
    logic               geo_interleaved = 1'b0;
    logic [PLANE_W-1:0] geo_planes      = 4'd8;
    logic               geo_mask        = 1'b0;
    logic               geo_compressed  = 1'b1;

    // decoder state of the prediction
    phase_t      dec_phase = PH_CMD;
    int unsigned lit_left, row_pos, plane_idx, emitted;
    bit          in_mask_row, img_done;

    // stimulus, expectations and bookkeeping
    in_item_t    body_q[$];
    out_item_t   expected_pixels[$];
    out_item_t   predicted, want;
    bit          sob_next;
    int          bytes_queued, bytes_accepted, results_checked, errors, geometries;
    int          burst_left, gap_left;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age;

    byterun1_bitplane_body_decoder_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // clamped image geometry
    function automatic int unsigned eff_width();
        int unsigned w;
        w = geo_width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (geo_height < 1) ? 1 : geo_height;
    endfunction

    function automatic int unsigned row_bytes();
        return geo_interleaved ? (eff_width() + 7) / 8 : eff_width();
    endfunction

    function automatic int unsigned depth();
        int unsigned d;
        d = geo_planes;
        if (!geo_interleaved) return 1;
        if (d < 1) d = 1;
        if (d > MAX_PLANES) d = MAX_PLANES;
        return d;
    endfunction

    function automatic int unsigned total_bytes();
        return eff_height() * depth() * row_bytes();
    endfunction

    function automatic void clear_decode();
        dec_phase   = PH_CMD;
        lit_left    = 0;
        row_pos     = 0;
        plane_idx   = 0;
        in_mask_row = 1'b0;
        emitted     = 0;
        img_done    = 1'b0;
    endfunction

    function automatic void start_next_row();
        row_pos     = 0;
        plane_idx   = 0;
        in_mask_row = 1'b0;
    endfunction

    // raw rows of odd pixel width are followed by one pad byte
    function automatic void close_raw_row();
        if (eff_width() % 2) begin
            start_next_row();
            dec_phase = PH_PAD;
        end else begin
            start_next_row();
        end
    endfunction

    // one run, clipped at the end of the image
    function automatic out_item_t emit_run(input logic [7:0] value, input int unsigned count);
        int unsigned left;
        out_item_t   r;
        left = total_bytes() - emitted;
        if (count > left) count = left;
        emitted += count;
        if (emitted >= total_bytes()) img_done = 1'b1;
        r.pixel_value  = value;
        r.repeat_count = 8'(count);
        r.image_done   = img_done;
        return r;
    endfunction

    // predicted outcome of one body byte; returns 1 when it yields a pixel run
    function automatic bit decode_body_byte(input in_item_t it, output out_item_t res);
        logic [7:0] b;
        bit         got;
        b   = it.stream_byte;
        got = 1'b0;
        res = '0;
        if (it.start_of_body) clear_decode();
        if (img_done || emitted >= total_bytes()) begin
            img_done = 1'b1;
            return 1'b0;
        end
        if (geo_compressed) begin
            case (dec_phase)
                PH_LIT: begin
                    lit_left = (lit_left - 1) & 8'hFF;
                    if (lit_left == 0) dec_phase = PH_CMD;
                    if (!in_mask_row) begin
                        res = emit_run(b, 1);
                        got = 1'b1;
                    end
                end
                PH_RUN: begin
                    dec_phase = PH_CMD;
                    if (!in_mask_row) begin
                        res = emit_run(b, lit_left);
                        got = 1'b1;
                    end
                end
                default: begin
                    // command byte; a left-over pad phase reads as one too
                    dec_phase = PH_CMD;
                    if (row_pos >= row_bytes()) begin
                        plane_idx = (plane_idx + 1) & 4'hF;
                        if (plane_idx >= depth() + (geo_mask ? 1 : 0)) start_next_row();
                        if (geo_mask && plane_idx == depth()) in_mask_row = 1'b1;
                        row_pos = 0;
                    end
                    if (b < CMD_NOP) begin
                        lit_left  = b + 1;
                        dec_phase = PH_LIT;
                        row_pos  += lit_left;
                    end else if (b > CMD_NOP) begin
                        lit_left  = 257 - b;
                        dec_phase = PH_RUN;
                        row_pos  += lit_left;
                    end
                end
            endcase
        end else if (dec_phase == PH_PAD) begin
            dec_phase = PH_CMD;
            start_next_row();
        end else begin
            dec_phase = PH_CMD;
            row_pos++;
            if (in_mask_row) begin
                if (row_pos >= row_bytes()) close_raw_row();
            end else begin
                res = emit_run(b, 1);
                got = 1'b1;
                if (row_pos >= row_bytes()) begin
                    row_pos   = 0;
                    plane_idx = (plane_idx + 1) & 4'hF;
                    if (plane_idx >= depth()) begin
                        if (geo_mask) in_mask_row = 1'b1;
                        else close_raw_row();
                    end
                end
            end
        end
        return got;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                bytes_accepted++;
                if (decode_body_byte(s_data, predicted)) expected_pixels.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (body_q.size() != 0) begin
                    s_data  <= body_q.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern rotated every cycle, reloaded now and then
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel run, expected none,", $time);
                $display("%0t:   got value %0h count %0d done %0b", $time,
                         m_data.pixel_value, m_data.repeat_count, m_data.image_done);
            end else begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (m_data.pixel_value !== want.pixel_value ||
                    m_data.repeat_count !== want.repeat_count ||
                    m_data.image_done !== want.image_done) begin
                    errors++;
                    $display("%0t: pixel run mismatch, expected value %0h count %0d done %0b,",
                             $time, want.pixel_value, want.repeat_count, want.image_done);
                    $display("%0t:   got value %0h count %0d done %0b", $time,
                             m_data.pixel_value, m_data.repeat_count, m_data.image_done);
                end
            end
        end
        if (pattern_age <= 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'h8001;
                default: ready_pattern = 16'($urandom) | 16'h0101;
            endcase
            pattern_age = $urandom_range(16, 96);
        end
        pattern_age--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        m_ready <= aresetn ? ready_pattern[0] : 1'b0;
    end

    task automatic push_byte(input logic [7:0] b);
        in_item_t it;
        it.stream_byte   = b;
        it.start_of_body = sob_next;
        body_q.push_back(it);
        sob_next = 1'b0;
        bytes_queued++;
    endtask

    // wait until every queued byte is taken and every run has come out
    task automatic settle();
        while (body_q.size() != 0 || s_valid || expected_pixels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input logic [INDEX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[DIM_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:        geo_width       = value[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:       geo_height      = value[DIM_W-1:0];
            CFG_INTERLEAVED_PLANES: geo_interleaved = value[0];
            CFG_PLANE_COUNT:        geo_planes      = value[PLANE_W-1:0];
            CFG_HAS_MASK_PLANE:     geo_mask        = value[0];
            CFG_COMPRESSED:         geo_compressed  = value[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int il, input int pc,
                                input int mk, input int cp);
        settle();
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
        write_register(CFG_INTERLEAVED_PLANES, il);
        write_register(CFG_PLANE_COUNT, pc);
        write_register(CFG_HAS_MASK_PLANE, mk);
        write_register(CFG_COMPRESSED, cp);
        geometries++;
    endtask

    // random geometry around a chosen width
    task automatic n_width_extreme(input int w);
        set_geometry(w,
                     ($urandom_range(0, 7) == 0) ? 2048 : $urandom_range(1, 5),
                     $urandom_range(0, 1),
                     ($urandom_range(0, 15) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8),
                     $urandom_range(0, 1),
                     ($urandom_range(0, 9) < 7) ? 1 : 0);
    endtask

    // one image body: well formed (maybe cut short) or noise with stray starts
    task automatic queue_image(input int budget);
        int r, p, left, n, first;
        if (bytes_queued >= ITEM_TARGET) return;
        first    = bytes_queued;
        sob_next = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(4, 40)) begin
                if ($urandom_range(0, 15) == 0) sob_next = 1'b1;
                push_byte(8'($urandom));
            end
            return;
        end
        if ($urandom_range(0, 7) == 0) budget = $urandom_range(2, 30);
        for (r = 0; r < eff_height(); r++) begin
            for (p = 0; p < depth() + (geo_mask ? 1 : 0); p++) begin
                left = row_bytes();
                while (left > 0) begin
                    if (bytes_queued - first >= budget || bytes_queued >= ITEM_TARGET) return;
                    if (!geo_compressed) begin
                        push_byte(8'($urandom));
                        left--;
                    end else if ($urandom_range(0, 15) == 0) begin
                        push_byte(CMD_NOP);
                    end else begin
                        n = $urandom_range(1, (left < 128) ? left : 128);
                        // now and then a run that crosses the row end
                        if ($urandom_range(0, 15) == 0) n = $urandom_range(1, 128);
                        if (n >= 2 && $urandom_range(0, 1)) begin
                            push_byte(8'(257 - n));
                            push_byte(8'($urandom));
                        end else begin
                            push_byte(8'(n - 1));
                            repeat (n) push_byte(8'($urandom));
                        end
                        left -= n;
                    end
                end
            end
            if (!geo_compressed && (eff_width() % 2)) push_byte(8'($urandom));
        end
        // trailing bytes past the end of the image
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
    endtask

    initial begin : stimulus
        int k;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: single literal, longest run, no-op, shortest run, literal of three
        sob_next = 1'b1;
        push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h81); push_byte(8'hFF);
        push_byte(CMD_NOP);
        push_byte(8'hFF); push_byte(8'hA5);
        push_byte(8'h02); push_byte(8'h5A); push_byte(8'hC3); push_byte(8'h80);

        // one pixel image: run clipped to one, byte after done, restart
        set_geometry(1, 1, 0, 1, 0, 1);
        sob_next = 1'b1;
        push_byte(8'h81); push_byte(8'h77);
        push_byte(8'h00);
        sob_next = 1'b1;
        push_byte(8'h00); push_byte(8'h12);

        // raw odd width with mask row and pad byte
        set_geometry(3, 2, 0, 1, 1, 0);
        sob_next = 1'b1;
        push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
        push_byte(8'h44); push_byte(8'h55); push_byte(8'h66);
        push_byte(8'h77);
        push_byte(8'h88); push_byte(8'h99); push_byte(8'hAA);
        push_byte(8'hBB);

        // random geometries, extremes first
        for (k = 0; bytes_queued < ITEM_TARGET; k++) begin
            case (k)
                0: set_geometry(2048, 2048, 0, 1, 0, 1);
                1: set_geometry(2048, 3, 1, 8, 1, 1);
                2: set_geometry(1, 2048, 0, 1, 0, 0);
                3: set_geometry(4095, 0, 1, 0, 0, 1);
                4: set_geometry(17, 2, 1, 15, 1, 0);
                default: begin
                    case ($urandom_range(0, 15))
                        0:       n_width_extreme(1);
                        1:       n_width_extreme(2048);
                        2:       n_width_extreme(0);
                        default: n_width_extreme($urandom_range(1, 40));
                    endcase
                end
            endcase
            repeat ($urandom_range(1, 4)) queue_image((k < 5) ? 250 : 400);
        end
        settle();

        $display("summary: %0d body bytes over %0d geometry settings, %0d pixel runs checked",
                 bytes_accepted, geometries, results_checked);
        $display("summary: raw and packed bodies, bitplanes, mask rows, clipping, %0d mismatches",
                 errors);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
sv/br1bd_pkg.sv
sv/br1bd_cfg.sv
sv/br1bd_step.sv
sv/byterun1_bitplane_body_decoder_unit.sv
sim/testbench.sv
